// ===== sv/scd_pkg.sv =====
// shared types and constants of the serial command decoder
package scd_pkg;

    // request codes carried in the action field
    localparam logic [2:0] OP_BYTE      = 3'd0;
    localparam logic [2:0] OP_RELEASE   = 3'd1;
    localparam logic [2:0] OP_SET_BREAK = 3'd2;
    localparam logic [2:0] OP_SET_INSTR = 3'd3;
    localparam logic [2:0] OP_SET_FRAME = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    // pending motor action codes
    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_TOP      = 4'd1;
    localparam logic [3:0] ACT_BOTTOM   = 4'd2;
    localparam logic [3:0] ACT_FRAME    = 4'd3;
    localparam logic [3:0] ACT_UP       = 4'd4;
    localparam logic [3:0] ACT_DOWN     = 4'd5;
    localparam logic [3:0] ACT_CAL      = 4'd6;
    localparam logic [3:0] ACT_SLOW     = 4'd7;
    localparam logic [3:0] ACT_RUN_UP   = 4'd8;
    localparam logic [3:0] ACT_RUN_DOWN = 4'd9;
    localparam logic [3:0] ACT_STEPPER  = 4'd10;

    // fixed command characters
    localparam logic [7:0] CHR_FULL_STOP = 8'h7a;  // 'z'
    localparam logic [7:0] CHR_STOP      = 8'h72;  // 'r'
    localparam logic [7:0] CHR_VENT_A    = 8'h65;  // 'e'
    localparam logic [7:0] CHR_VENT_B    = 8'h6a;  // 'j'
    localparam logic [7:0] CHR_NOP_K     = 8'h6b;  // 'k'
    localparam logic [7:0] CHR_UP        = 8'h66;  // 'f'
    localparam logic [7:0] CHR_DOWN      = 8'h67;  // 'g'
    localparam logic [7:0] CHR_CAL       = 8'h68;  // 'h'
    localparam logic [7:0] CHR_SLOW      = 8'h69;  // 'i'
    localparam logic [7:0] CHR_NOP_A     = 8'h41;  // 'A'

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MARKER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_UP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_DOWN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READY        = 3'd6;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;

    // byte class found by the front, in decode priority
    typedef enum logic [3:0] {
        CLS_FULL_STOP = 4'd0,
        CLS_STOP      = 4'd1,
        CLS_TOP       = 4'd2,
        CLS_BOTTOM    = 4'd3,
        CLS_MARKER    = 4'd4,
        CLS_IGNORE    = 4'd5,
        CLS_VENT      = 4'd6,
        CLS_UP        = 4'd7,
        CLS_DOWN      = 4'd8,
        CLS_CAL       = 4'd9,
        CLS_SLOW      = 4'd10,
        CLS_RUN_UP    = 4'd11,
        CLS_RUN_DOWN  = 4'd12,
        CLS_STEPPER   = 4'd13
    } byte_class_t;

    // configured codes
    typedef struct packed {
        logic [7:0] frame_marker_code;
        logic [7:0] top_limit_code;
        logic [7:0] bottom_limit_code;
        logic [7:0] unlock_code;
        logic [7:0] run_up_code;
        logic [7:0] run_down_code;
        logic [7:0] ready_code;
    } cfg_t;

    // command beat
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [3:0] match_action;
        logic [2:0] entry_index;
    } cmd_item_t;

    // response beat
    typedef struct packed {
        logic [7:0] stepper_byte;
        logic       break_request;
        logic [3:0] pending_action;
        logic       in_frame;
        logic       moved_since_vent;
        logic       sleep_driver;
        logic       send_ready;
        logic       frame_overflow;
        logic [7:0] read_value;
    } rsp_item_t;

    // classified command held in the queue
    typedef struct packed {
        logic [2:0]  action;
        byte_class_t cls;
        logic [7:0]  data_byte;
        logic [3:0]  match_action;
        logic [2:0]  entry_index;
    } queue_entry_t;

endpackage

// ===== sv/scd_cmd_if.sv =====
// command channel: valid, ready and one command beat
interface scd_cmd_if;
    logic                 valid;
    logic                 ready;
    scd_pkg::cmd_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/scd_rsp_if.sv =====
// response channel: valid, ready and one response beat
interface scd_rsp_if;
    logic                 valid;
    logic                 ready;
    scd_pkg::rsp_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/scd_ram.sv =====
// generic single-write, single-read ram with registered read data
module scd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/scd_front.sv =====
// front end: accepts command beats and classifies the received byte
module scd_front (
    scd_cmd_if.sink                 cmd,
    input  scd_pkg::cfg_t           cfg,
    input  logic                    q_full,
    output logic                    q_push,
    output scd_pkg::queue_entry_t   q_entry
);

    logic [7:0]           b;
    scd_pkg::byte_class_t cls;

    assign b = cmd.data.data_byte;

    // priority compare of the byte against fixed and configured codes
    always_comb
    begin
        if (b == scd_pkg::CHR_FULL_STOP)
            cls = scd_pkg::CLS_FULL_STOP;
        else if (b == scd_pkg::CHR_STOP)
            cls = scd_pkg::CLS_STOP;
        else if (b == cfg.top_limit_code)
            cls = scd_pkg::CLS_TOP;
        else if (b == cfg.bottom_limit_code)
            cls = scd_pkg::CLS_BOTTOM;
        else if (b == cfg.frame_marker_code)
            cls = scd_pkg::CLS_MARKER;
        else if (b == scd_pkg::CHR_NOP_A || b == cfg.unlock_code || b == scd_pkg::CHR_NOP_K)
            cls = scd_pkg::CLS_IGNORE;
        else if (b == scd_pkg::CHR_VENT_A || b == scd_pkg::CHR_VENT_B)
            cls = scd_pkg::CLS_VENT;
        else if (b == scd_pkg::CHR_UP)
            cls = scd_pkg::CLS_UP;
        else if (b == scd_pkg::CHR_DOWN)
            cls = scd_pkg::CLS_DOWN;
        else if (b == scd_pkg::CHR_CAL)
            cls = scd_pkg::CLS_CAL;
        else if (b == scd_pkg::CHR_SLOW)
            cls = scd_pkg::CLS_SLOW;
        else if (b == cfg.run_up_code)
            cls = scd_pkg::CLS_RUN_UP;
        else if (b == cfg.run_down_code)
            cls = scd_pkg::CLS_RUN_DOWN;
        else
            cls = scd_pkg::CLS_STEPPER;
    end

    // beat handshake into the queue
    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;

    always_comb
    begin
        q_entry.action       = cmd.data.action;
        q_entry.cls          = cls;
        q_entry.data_byte    = b;
        q_entry.match_action = cmd.data.match_action;
        q_entry.entry_index  = cmd.data.entry_index;
    end

endmodule

// ===== sv/scd_queue.sv =====
// short fifo of classified commands between front and back
module scd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  scd_pkg::queue_entry_t   push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output scd_pkg::queue_entry_t   head_entry
);

    localparam int unsigned CNT_W = $clog2(scd_pkg::QUEUE_DEPTH + 1);

    scd_pkg::queue_entry_t              slot_reg [scd_pkg::QUEUE_DEPTH];
    logic [scd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [scd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(scd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/scd_back.sv =====
// back end: executes commands, owns the decoder state, frame store and response register
module scd_back #(
    parameter int unsigned FRAME_DEPTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  scd_pkg::queue_entry_t   head_entry,
    output logic                    pop,
    scd_rsp_if.source               rsp
);

    localparam int unsigned AW  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int unsigned WPW = $clog2(FRAME_DEPTH + 1);
    localparam int unsigned EW  = (AW > 3) ? AW : 3;

    // decoder state
    logic [7:0]             instr_reg, instr_next;
    logic                   brk_reg, brk_next;
    logic [3:0]             act_reg, act_next;
    logic                   frm_reg, frm_next;
    logic                   vent_reg, vent_next;
    logic [WPW-1:0]         wp_reg, wp_next;
    logic [FRAME_DEPTH-1:0] vld_reg, vld_next;

    // response register
    logic                   out_valid_reg, out_valid_next;
    scd_pkg::rsp_item_t     out_reg, out_next;
    logic                   hit_reg, hit_next;

    // frame store ports
    logic                   st_we;
    logic [AW-1:0]          st_waddr;
    logic                   st_re;
    logic [AW-1:0]          st_raddr;
    logic [7:0]             st_rdata;

    logic [EW-1:0]          idx_ext;
    logic                   idx_in_range;
    logic                   store_byte;
    logic                   room;
    scd_pkg::byte_class_t   cls;

    assign cls          = head_entry.cls;
    assign idx_ext      = EW'(head_entry.entry_index);
    assign st_raddr     = idx_ext[AW-1:0];
    assign idx_in_range = (32'(head_entry.entry_index) < FRAME_DEPTH);
    assign st_waddr     = wp_reg[AW-1:0];
    assign room         = (wp_reg < WPW'(FRAME_DEPTH));

    // take the head when the response register is free or being drained
    assign pop = head_valid && (!out_valid_reg || rsp.ready);

    // a byte is stored while framing unless it is a stop, limit or marker code
    assign store_byte = frm_reg
                     && cls != scd_pkg::CLS_FULL_STOP && cls != scd_pkg::CLS_STOP
                     && cls != scd_pkg::CLS_TOP && cls != scd_pkg::CLS_BOTTOM
                     && cls != scd_pkg::CLS_MARKER;

    // command execution
    always_comb
    begin
        instr_next = instr_reg;
        brk_next   = brk_reg;
        act_next   = act_reg;
        frm_next   = frm_reg;
        vent_next  = vent_reg;
        wp_next    = wp_reg;
        vld_next   = vld_reg;
        st_we      = 1'b0;
        st_re      = 1'b0;
        hit_next   = hit_reg;
        out_next   = out_reg;

        if (pop)
        begin
            out_next.sleep_driver   = 1'b0;
            out_next.send_ready     = 1'b0;
            out_next.frame_overflow = 1'b0;
            out_next.read_value     = 8'd0;
            hit_next                = 1'b0;

            case (head_entry.action)
                scd_pkg::OP_BYTE:
                begin
                    if (store_byte)
                    begin
                        if (room)
                        begin
                            st_we              = 1'b1;
                            vld_next[st_waddr] = 1'b1;
                            wp_next            = wp_reg + 1'b1;
                        end
                        else
                        begin
                            out_next.frame_overflow = 1'b1;
                        end
                    end
                    else
                    begin
                        case (cls)
                            scd_pkg::CLS_FULL_STOP:
                            begin
                                instr_next            = 8'd0;
                                brk_next              = 1'b1;
                                act_next              = scd_pkg::ACT_NONE;
                                frm_next              = 1'b0;
                                out_next.sleep_driver = 1'b1;
                                out_next.send_ready   = 1'b1;
                            end
                            scd_pkg::CLS_STOP:
                            begin
                                instr_next            = 8'd0;
                                brk_next              = 1'b1;
                                act_next              = scd_pkg::ACT_NONE;
                                out_next.sleep_driver = 1'b1;
                            end
                            scd_pkg::CLS_TOP:
                            begin
                                act_next   = scd_pkg::ACT_TOP;
                                brk_next   = 1'b1;
                                instr_next = 8'd0;
                            end
                            scd_pkg::CLS_BOTTOM:
                            begin
                                act_next   = scd_pkg::ACT_BOTTOM;
                                brk_next   = 1'b1;
                                instr_next = 8'd0;
                            end
                            scd_pkg::CLS_MARKER:
                            begin
                                if (!frm_reg)
                                begin
                                    frm_next = 1'b1;
                                    wp_next  = '0;
                                end
                                else
                                begin
                                    frm_next = 1'b0;
                                    act_next = scd_pkg::ACT_FRAME;
                                end
                            end
                            scd_pkg::CLS_IGNORE:
                            begin
                                instr_next = instr_reg;
                            end
                            scd_pkg::CLS_VENT:
                            begin
                                vent_next = 1'b0;
                            end
                            scd_pkg::CLS_UP:
                            begin
                                brk_next  = 1'b1;
                                act_next  = scd_pkg::ACT_UP;
                                vent_next = 1'b1;
                            end
                            scd_pkg::CLS_DOWN:
                            begin
                                brk_next  = 1'b1;
                                act_next  = scd_pkg::ACT_DOWN;
                                vent_next = 1'b1;
                            end
                            scd_pkg::CLS_CAL:
                            begin
                                act_next   = scd_pkg::ACT_CAL;
                                brk_next   = 1'b1;
                                instr_next = 8'd0;
                            end
                            scd_pkg::CLS_SLOW:
                            begin
                                brk_next = 1'b1;
                                act_next = scd_pkg::ACT_SLOW;
                            end
                            scd_pkg::CLS_RUN_UP:
                            begin
                                brk_next = 1'b1;
                                act_next = scd_pkg::ACT_RUN_UP;
                            end
                            scd_pkg::CLS_RUN_DOWN:
                            begin
                                brk_next = 1'b1;
                                act_next = scd_pkg::ACT_RUN_DOWN;
                            end
                            default:
                            begin
                                instr_next = head_entry.data_byte;
                                act_next   = scd_pkg::ACT_STEPPER;
                                brk_next   = 1'b1;
                            end
                        endcase
                    end
                end
                scd_pkg::OP_RELEASE:
                begin
                    if (head_entry.match_action == act_reg)
                        act_next = scd_pkg::ACT_NONE;
                end
                scd_pkg::OP_SET_BREAK:
                begin
                    brk_next = head_entry.data_byte[0];
                end
                scd_pkg::OP_SET_INSTR:
                begin
                    instr_next = head_entry.data_byte;
                end
                scd_pkg::OP_SET_FRAME:
                begin
                    frm_next = head_entry.data_byte[0];
                end
                scd_pkg::OP_READ:
                begin
                    // never-written entries read as zero
                    st_re    = idx_in_range;
                    hit_next = idx_in_range && vld_reg[st_raddr];
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase

            out_next.stepper_byte     = instr_next;
            out_next.break_request    = brk_next;
            out_next.pending_action   = act_next;
            out_next.in_frame         = frm_next;
            out_next.moved_since_vent = vent_next;
        end
    end

    // response valid
    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instr_reg     <= 8'd0;
            brk_reg       <= 1'b0;
            act_reg       <= scd_pkg::ACT_NONE;
            frm_reg       <= 1'b0;
            vent_reg      <= 1'b1;
            wp_reg        <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            instr_reg     <= instr_next;
            brk_reg       <= brk_next;
            act_reg       <= act_next;
            frm_reg       <= frm_next;
            vent_reg      <= vent_next;
            wp_reg        <= wp_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        hit_reg <= hit_next;
    end

    // frame store
    scd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (head_entry.data_byte),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // read data joins the response when its entry was hit
    always_comb
    begin
        rsp.data            = out_reg;
        rsp.data.read_value = hit_reg ? st_rdata : 8'd0;
    end

    assign rsp.valid = out_valid_reg;

endmodule

// ===== sv/serial_command_decoder_unit.sv =====
// top level of the serial command decoder: config registers, front, queue and back
//
//  channel  dir  beat        handshake
//  cmd      in   cmd_item_t  valid/ready
//  rsp      out  rsp_item_t  valid/ready
//  cfg      in   8-bit data  cfg_we, cfg_index, no wait
//
//  one command per cycle sustained while rsp is ready; a response follows its command
//  beat through the queue register and then the response register
//  a two-entry queue lets the front keep taking beats while a response is stalled
//  after reset the block is ready at once; the frame store reads zero via per-entry valid bits
//  the store is one ram, written by frame bytes and read by the read request
module serial_command_decoder_unit #(
    parameter int unsigned FRAME_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    scd_cmd_if.sink                           cmd,
    scd_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);

    scd_pkg::cfg_t          cfg_reg, cfg_next;
    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_head_valid;
    scd_pkg::queue_entry_t  q_push_entry;
    scd_pkg::queue_entry_t  q_head_entry;

    // config register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scd_pkg::CFG_FRAME_MARKER: cfg_next.frame_marker_code = cfg_data;
                scd_pkg::CFG_TOP_LIMIT:    cfg_next.top_limit_code    = cfg_data;
                scd_pkg::CFG_BOTTOM_LIMIT: cfg_next.bottom_limit_code = cfg_data;
                scd_pkg::CFG_UNLOCK:       cfg_next.unlock_code       = cfg_data;
                scd_pkg::CFG_RUN_UP:       cfg_next.run_up_code       = cfg_data;
                scd_pkg::CFG_RUN_DOWN:     cfg_next.run_down_code     = cfg_data;
                scd_pkg::CFG_READY:        cfg_next.ready_code        = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_marker_code <= 8'd169;
            cfg_reg.top_limit_code    <= 8'd240;
            cfg_reg.bottom_limit_code <= 8'd241;
            cfg_reg.unlock_code       <= 8'd242;
            cfg_reg.run_up_code       <= 8'd243;
            cfg_reg.run_down_code     <= 8'd244;
            cfg_reg.ready_code        <= 8'd82;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // accept and classify
    scd_front u_front (
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_push_entry)
    );

    // decoupling queue
    scd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    // execute and respond
    scd_back #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .rsp        (rsp)
    );

endmodule
